>>> design/assert_macros.svh
// Assertion macros shared by the parity checker RTL.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TDP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define TDP_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define TDP_ASSERT(lbl, clk, rstn, prop)
`define TDP_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

>>> design/tdp_pkg.sv
// Package for the two-dimensional parity checker: sizes, register
// indexes, cell control types and the dimension clamp. No dependencies.
package tdp_pkg;

    localparam int MAX_DIM = 32;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = 6;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = 6'd9;
    localparam logic [DIM_W-1:0] DIM_MIN   = 6'd2;
    localparam logic [CNT_W-1:0] CNT_MAX   = 5'd31;

    typedef struct packed {
        logic clear;
        logic step;
        logic wrap;
        logic data_bit;
        logic row_end;
        logic capture;
    } cell_ctl_t;

    typedef struct packed {
        logic hit_par;
        logic hit_fail;
    } cell_stat_t;

    function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] d;
        begin
            if (dim < DIM_MIN)
                d = DIM_MIN;
            else if (dim > DIM_W'(MAX_DIM))
                d = DIM_W'(MAX_DIM);
            else
                d = dim;
            last_index = IDX_W'(d - 1'b1);
        end
    endfunction

endpackage

>>> design/tdp_if.sv
// Request channel interfaces of the parity checker: received bits in,
// frame reports out. No dependencies.
interface tdp_bit_if;
    logic valid;
    logic ready;
    logic rx_bit;

    modport source (output valid, output rx_bit, input ready);
    modport sink (input valid, input rx_bit, output ready);
endinterface

interface tdp_rep_if;
    logic       valid;
    logic       ready;
    logic [4:0] bad_row_count;
    logic [4:0] bad_col_count;
    logic       single_error;
    logic [4:0] error_row;
    logic [4:0] error_col;
    logic       received_bit;
    logic       corrected_bit;

    modport source (output valid, output bad_row_count, output bad_col_count,
                    output single_error, output error_row, output error_col,
                    output received_bit, output corrected_bit, input ready);
    modport sink (input valid, input bad_row_count, input bad_col_count,
                  input single_error, input error_row, input error_col,
                  input received_bit, input corrected_bit, output ready);
endinterface

>>> design/tdp_cell.sv
// One column cell: column parity, current row bit, failed row bit and
// the column token passed to the next cell. Uses tdp_pkg.
module tdp_cell
    import tdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic       rx_bit,
    input  logic       sel_in,
    output logic       token_out,
    output cell_stat_t stat
);

    logic col_par_reg, col_par_next;
    logic cur_reg, cur_next;
    logic fail_reg, fail_next;
    logic token_reg, token_next;

    always_comb
    begin
        col_par_next = col_par_reg;
        cur_next     = cur_reg;
        fail_next    = fail_reg;
        token_next   = token_reg;
        if (ctl.clear)
        begin
            col_par_next = 1'b0;
            cur_next     = 1'b0;
            fail_next    = 1'b0;
            token_next   = 1'b0;
        end
        else if (ctl.step)
        begin
            token_next = ctl.wrap ? 1'b0 : sel_in;
            if (ctl.data_bit && sel_in)
            begin
                col_par_next = col_par_reg ^ rx_bit;
                cur_next     = cur_reg | rx_bit;
            end
            if (ctl.row_end)
            begin
                cur_next = 1'b0;
                if (ctl.capture)
                    fail_next = cur_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_par_reg <= 1'b0;
            cur_reg     <= 1'b0;
            fail_reg    <= 1'b0;
            token_reg   <= 1'b0;
        end
        else
        begin
            col_par_reg <= col_par_next;
            cur_reg     <= cur_next;
            fail_reg    <= fail_next;
            token_reg   <= token_next;
        end
    end

    assign token_out     = token_reg;
    assign stat.hit_par  = sel_in & col_par_reg;
    assign stat.hit_fail = sel_in & fail_reg;

endmodule

>>> design/tdp_ctrl.sv
// Frame sequencer: configuration, row and column counters, parity checks,
// failure counts and the report register. Uses tdp_pkg, tdp_if, macros.
`include "assert_macros.svh"

module tdp_ctrl
    import tdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    tdp_bit_if.sink              bits,
    tdp_rep_if.source            report,
    input  logic [MAX_DIM-1:0]   par_hits,
    input  logic [MAX_DIM-1:0]   fail_hits,
    output cell_ctl_t            ctl,
    output logic                 col0
);

    logic [DIM_W-1:0] rows_reg, rows_next;
    logic [DIM_W-1:0] cols_reg, cols_next;
    logic [IDX_W-1:0] row_idx_reg, row_idx_next;
    logic [IDX_W-1:0] col_idx_reg, col_idx_next;
    logic             row_par_reg, row_par_next;
    logic [IDX_W-1:0] bad_row_reg, bad_row_next;
    logic [IDX_W-1:0] bad_col_reg, bad_col_next;
    logic [CNT_W-1:0] row_fail_reg, row_fail_next;
    logic [CNT_W-1:0] col_fail_reg, col_fail_next;
    logic             rx_sel_reg, rx_sel_next;
    logic             res_valid_reg, res_valid_next;

    logic [CNT_W-1:0] rep_rows_reg, rep_cols_reg;
    logic             rep_single_reg;
    logic [CNT_W-1:0] rep_erow_reg, rep_ecol_reg;
    logic             rep_rx_reg, rep_fix_reg;

    logic [IDX_W-1:0] rows_last, cols_last;
    logic             last_row, last_col;
    logic             acc, b, cfg_hit;
    logic             row_bad, col_bad, frame_end, single;

    assign rows_last = last_index(rows_reg);
    assign cols_last = last_index(cols_reg);
    assign last_row  = row_idx_reg >= rows_last;
    assign last_col  = col_idx_reg >= cols_last;

    assign bits.ready = !res_valid_reg || report.ready;
    assign acc        = bits.valid && bits.ready;
    assign b          = bits.rx_bit;
    assign cfg_hit    = cfg_we && (cfg_index == CFG_FRAME_ROWS || cfg_index == CFG_FRAME_COLS);

    assign row_bad   = acc && !last_row && last_col && (b != row_par_reg);
    assign col_bad   = acc && last_row && !last_col && (b != (|par_hits));
    assign frame_end = acc && last_row && last_col;
    assign single    = (row_fail_reg == CNT_W'(1)) && (col_fail_reg == CNT_W'(1));

    assign ctl.clear    = cfg_hit || frame_end;
    assign ctl.step     = acc;
    assign ctl.wrap     = last_col;
    assign ctl.data_bit = acc && !last_row && !last_col;
    assign ctl.row_end  = acc && !last_row && last_col;
    assign ctl.capture  = row_bad && (row_fail_reg == '0);
    assign col0         = (col_idx_reg == '0);

    always_comb
    begin
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        row_idx_next  = row_idx_reg;
        col_idx_next  = col_idx_reg;
        row_par_next  = row_par_reg;
        bad_row_next  = bad_row_reg;
        bad_col_next  = bad_col_reg;
        row_fail_next = row_fail_reg;
        col_fail_next = col_fail_reg;
        rx_sel_next   = rx_sel_reg;

        if (acc)
        begin
            if (ctl.data_bit)
                row_par_next = row_par_reg ^ b;
            if (ctl.row_end)
                row_par_next = 1'b0;
            if (row_bad)
            begin
                if (row_fail_reg == '0)
                    bad_row_next = row_idx_reg;
                if (row_fail_reg != CNT_MAX)
                    row_fail_next = row_fail_reg + 1'b1;
            end
            if (col_bad)
            begin
                if (col_fail_reg == '0)
                begin
                    bad_col_next = col_idx_reg;
                    rx_sel_next  = |fail_hits;
                end
                if (col_fail_reg != CNT_MAX)
                    col_fail_next = col_fail_reg + 1'b1;
            end
            if (last_col)
            begin
                col_idx_next = '0;
                row_idx_next = row_idx_reg + 1'b1;
            end
            else
                col_idx_next = col_idx_reg + 1'b1;
        end

        if (ctl.clear)
        begin
            row_idx_next  = '0;
            col_idx_next  = '0;
            row_par_next  = 1'b0;
            bad_row_next  = '0;
            bad_col_next  = '0;
            row_fail_next = '0;
            col_fail_next = '0;
            rx_sel_next   = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_ROWS: rows_next = cfg_data;
                CFG_FRAME_COLS: cols_next = cfg_data;
                default: ;
            endcase
        end

        if (frame_end)
            res_valid_next = 1'b1;
        else if (report.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= DIM_RESET;
            cols_reg      <= DIM_RESET;
            row_idx_reg   <= '0;
            col_idx_reg   <= '0;
            row_par_reg   <= 1'b0;
            bad_row_reg   <= '0;
            bad_col_reg   <= '0;
            row_fail_reg  <= '0;
            col_fail_reg  <= '0;
            rx_sel_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            row_idx_reg   <= row_idx_next;
            col_idx_reg   <= col_idx_next;
            row_par_reg   <= row_par_next;
            bad_row_reg   <= bad_row_next;
            bad_col_reg   <= bad_col_next;
            row_fail_reg  <= row_fail_next;
            col_fail_reg  <= col_fail_next;
            rx_sel_reg    <= rx_sel_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            rep_rows_reg   <= row_fail_reg;
            rep_cols_reg   <= col_fail_reg;
            rep_single_reg <= single;
            rep_erow_reg   <= single ? CNT_W'(bad_row_reg) : '0;
            rep_ecol_reg   <= single ? CNT_W'(bad_col_reg) : '0;
            rep_rx_reg     <= single && rx_sel_reg;
            rep_fix_reg    <= single && !rx_sel_reg;
        end
    end

    assign report.valid         = res_valid_reg;
    assign report.bad_row_count = rep_rows_reg;
    assign report.bad_col_count = rep_cols_reg;
    assign report.single_error  = rep_single_reg;
    assign report.error_row     = rep_erow_reg;
    assign report.error_col     = rep_ecol_reg;
    assign report.received_bit  = rep_rx_reg;
    assign report.corrected_bit = rep_fix_reg;

    `TDP_ASSERT(a_row_in_frame, clk, rst_n, row_idx_reg <= rows_last)
    `TDP_ASSERT(a_col_in_frame, clk, rst_n, col_idx_reg <= cols_last)
    `TDP_ASSERT_NEVER(a_col_fail_early, clk, rst_n, col_fail_reg != '0 && !last_row)
    `TDP_ASSERT(a_report_loads, clk, rst_n, frame_end |=> res_valid_reg)

endmodule

>>> design/two_d_parity_checker.sv
// Top level of the two-dimensional parity checker: sequencer plus a chain
// of column cells. Uses tdp_pkg, tdp_if, tdp_cell, tdp_ctrl, macros.
//
//  channel   dir  payload                                     per
//  bits      in   rx_bit                                      frame bit
//  report    out  counts, single_error, row/col, rx/fix bits  frame
//  cfg_*     in   frame_rows (0), frame_cols (1), 6 bits      write
//
// One bit is taken every cycle unless a waiting report stalls input; the column token moves one cell per bit.
// The report is registered the cycle after the frame's last bit.
// A waiting report stalls input only while report.ready is low.
// Reset and any frame_rows/frame_cols write restart the frame at row 0.
`include "assert_macros.svh"

module two_d_parity_checker
    import tdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    tdp_bit_if.sink              bits,
    tdp_rep_if.source            report
);

    cell_ctl_t          ctl;
    logic               col0;
    logic [MAX_DIM-1:0] sel;
    logic [MAX_DIM-1:0] token;
    logic [MAX_DIM-1:0] par_hits;
    logic [MAX_DIM-1:0] fail_hits;
    cell_stat_t         stat [MAX_DIM];

    tdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bits      (bits),
        .report    (report),
        .par_hits  (par_hits),
        .fail_hits (fail_hits),
        .ctl       (ctl),
        .col0      (col0)
    );

    assign sel[0] = col0;

    for (genvar i = 0; i < MAX_DIM; i++)
    begin : g_cell
        if (i > 0)
        begin : g_link
            assign sel[i] = token[i-1];
        end
        tdp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .rx_bit    (bits.rx_bit),
            .sel_in    (sel[i]),
            .token_out (token[i]),
            .stat      (stat[i])
        );
        assign par_hits[i]  = stat[i].hit_par;
        assign fail_hits[i] = stat[i].hit_fail;
    end

    `TDP_ASSERT(a_one_active_cell, clk, rst_n, $onehot(sel))
    `TDP_ASSERT(a_clear_restarts, clk, rst_n, ctl.clear |=> sel[0])
    `TDP_ASSERT_NEVER(a_par_hit_stray, clk, rst_n, !$onehot0(par_hits))

endmodule

>>> tb/tb_two_d_parity_checker.sv
// Self-checking testbench for two_d_parity_checker: frames of received bits
// go in, frame reports come out and are checked against a local predictor.
// Depends on tdp_pkg, tdp_bit_if / tdp_rep_if and the two_d_parity_checker RTL.
module tb_two_d_parity_checker;
    import tdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BITS = 590;
    localparam int SETTLE      = 8;
    localparam int LONG_HOLD   = 150;
    localparam int MAX_SHOWN   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] bad_rows;
        logic [CNT_W-1:0] bad_cols;
        logic             single;
        logic [IDX_W-1:0] err_row;
        logic [IDX_W-1:0] err_col;
        logic             rx;
        logic             fix;
    } frame_report_t;

    typedef struct packed {
        logic          rx;
        logic          typed;
        frame_report_t rep;
    } bit_row_t;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_ONE_FLIP,
        FRAME_FEW_FLIPS,
        FRAME_NOISE,
        FRAME_ALL_PARITY_BAD
    } frame_kind_t;

    localparam frame_report_t REP_CLEAN    = '0;
    localparam frame_report_t REP_FIX_ONE  = {5'd1, 5'd1, 1'b1, 5'd0, 5'd0, 1'b1, 1'b0};
    localparam frame_report_t REP_FIX_ZERO = {5'd1, 5'd1, 1'b1, 5'd0, 5'd0, 1'b0, 1'b1};
    localparam frame_report_t REP_ROW_ONLY = {5'd1, 5'd0, 1'b0, 5'd0, 5'd0, 1'b0, 1'b0};
    localparam frame_report_t REP_COL_ONLY = {5'd0, 5'd1, 1'b0, 5'd0, 5'd0, 1'b0, 1'b0};

    localparam int DIRECTED_LEN = 28;

    // 2x2 frames: data, row parity, column parity, corner
    bit_row_t directed_rows [0:DIRECTED_LEN-1] = '{
        '{1'b0, 1'b0, REP_CLEAN}, '{1'b0, 1'b0, REP_CLEAN},
        '{1'b0, 1'b0, REP_CLEAN}, '{1'b0, 1'b1, REP_CLEAN},
        '{1'b1, 1'b0, REP_CLEAN}, '{1'b0, 1'b0, REP_CLEAN},
        '{1'b0, 1'b0, REP_CLEAN}, '{1'b0, 1'b1, REP_FIX_ONE},
        '{1'b0, 1'b0, REP_CLEAN}, '{1'b1, 1'b0, REP_CLEAN},
        '{1'b0, 1'b0, REP_CLEAN}, '{1'b0, 1'b1, REP_ROW_ONLY},
        '{1'b0, 1'b0, REP_CLEAN}, '{1'b0, 1'b0, REP_CLEAN},
        '{1'b1, 1'b0, REP_CLEAN}, '{1'b0, 1'b1, REP_COL_ONLY},
        '{1'b1, 1'b0, REP_CLEAN}, '{1'b1, 1'b0, REP_CLEAN},
        '{1'b1, 1'b0, REP_CLEAN}, '{1'b1, 1'b1, REP_CLEAN},
        '{1'b0, 1'b0, REP_CLEAN}, '{1'b0, 1'b0, REP_CLEAN},
        '{1'b0, 1'b0, REP_CLEAN}, '{1'b1, 1'b1, REP_CLEAN},
        '{1'b0, 1'b0, REP_CLEAN}, '{1'b1, 1'b0, REP_CLEAN},
        '{1'b1, 1'b0, REP_CLEAN}, '{1'b0, 1'b1, REP_FIX_ZERO}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    tdp_bit_if bits_ch ();
    tdp_rep_if rep_ch ();

    two_d_parity_checker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bits      (bits_ch),
        .report    (rep_ch)
    );

    always #10 clk = ~clk;

    // predictor state
    logic [DIM_W-1:0]   rows_cfg;
    logic [DIM_W-1:0]   cols_cfg;
    logic [IDX_W-1:0]   cur_row;
    logic [IDX_W-1:0]   cur_col;
    logic               row_par;
    logic [MAX_DIM-1:0] col_par;
    logic [MAX_DIM-1:0] row_bits;
    logic [MAX_DIM-1:0] bad_row_bits;
    logic [IDX_W-1:0]   bad_row_at;
    logic [IDX_W-1:0]   bad_col_at;
    logic [CNT_W-1:0]   rows_failed;
    logic [CNT_W-1:0]   cols_failed;

    frame_report_t pending_reports [$];
    int  mismatch_count = 0;
    int  bits_sent = 0;
    int  hold_off_cycles = 0;
    bit  idle_on = 1'b1;

    function automatic int dim_of(input logic [DIM_W-1:0] raw);
        if (raw < DIM_MIN)
            return int'(DIM_MIN);
        if (int'(raw) > MAX_DIM)
            return MAX_DIM;
        return int'(raw);
    endfunction

    task automatic clear_frame();
        cur_row      = '0;
        cur_col      = '0;
        row_par      = 1'b0;
        col_par      = '0;
        row_bits     = '0;
        bad_row_bits = '0;
        bad_row_at   = '0;
        bad_col_at   = '0;
        rows_failed  = '0;
        cols_failed  = '0;
    endtask

    task automatic parity_step(input logic b, output bit done, output frame_report_t rep);
        int  nrows;
        int  ncols;
        bit  at_last_row;
        bit  at_last_col;
        nrows = dim_of(rows_cfg);
        ncols = dim_of(cols_cfg);
        at_last_row = int'(cur_row) >= nrows - 1;
        at_last_col = int'(cur_col) >= ncols - 1;
        done = 1'b0;
        rep  = REP_CLEAN;
        if (!at_last_row)
        begin
            if (!at_last_col)
            begin
                row_par ^= b;
                if (b)
                begin
                    col_par[cur_col]  = ~col_par[cur_col];
                    row_bits[cur_col] = 1'b1;
                end
            end
            else
            begin
                if (b != row_par)
                begin
                    if (rows_failed == 0)
                    begin
                        bad_row_at   = cur_row;
                        bad_row_bits = row_bits;
                    end
                    if (rows_failed != CNT_MAX)
                        rows_failed++;
                end
                row_par  = 1'b0;
                row_bits = '0;
            end
        end
        else if (!at_last_col)
        begin
            if (b != col_par[cur_col])
            begin
                if (cols_failed == 0)
                    bad_col_at = cur_col;
                if (cols_failed != CNT_MAX)
                    cols_failed++;
            end
        end
        if (!at_last_col)
            cur_col++;
        else
        begin
            cur_col = '0;
            if (!at_last_row)
                cur_row++;
            else
            begin
                done = 1'b1;
                rep.bad_rows = rows_failed;
                rep.bad_cols = cols_failed;
                rep.single   = (rows_failed == 1) && (cols_failed == 1);
                if (rep.single)
                begin
                    rep.err_row = bad_row_at;
                    rep.err_col = bad_col_at;
                    rep.rx      = bad_row_bits[bad_col_at];
                    rep.fix     = ~bad_row_bits[bad_col_at];
                end
                clear_frame();
            end
        end
    endtask

    task automatic push_bit(input logic b, input logic typed, input frame_report_t typed_rep);
        int            gap;
        bit            done;
        frame_report_t rep;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            bits_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bits_ch.valid  <= 1'b1;
        bits_ch.rx_bit <= b;
        do @(posedge clk); while (bits_ch.ready !== 1'b1);
        bits_sent++;
        parity_step(b, done, rep);
        if (done)
            pending_reports.push_back(typed ? typed_rep : rep);
    endtask

    task automatic drain();
        bits_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] r_raw, input logic [DIM_W-1:0] c_raw);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_ROWS;
        cfg_data  <= r_raw;
        @(posedge clk);
        rows_cfg = r_raw;
        clear_frame();
        cfg_index <= CFG_FRAME_COLS;
        cfg_data  <= c_raw;
        @(posedge clk);
        cols_cfg = c_raw;
        clear_frame();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic poke_spare_reg();
        cfg_we    <= 1'b1;
        cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        cfg_data  <= DIM_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frame(input int nrows, input int ncols, input frame_kind_t kind,
                              input int split_at);
        logic [MAX_DIM-1:0] grid [MAX_DIM];
        int r;
        int c;
        int k;
        int flips;
        for (r = 0; r < nrows - 1; r++)
        begin
            grid[r] = $urandom;
            grid[r][ncols-1] = 1'b0;
            for (c = 0; c < ncols - 1; c++)
                grid[r][ncols-1] ^= grid[r][c];
        end
        grid[nrows-1] = '0;
        for (c = 0; c < ncols - 1; c++)
            for (r = 0; r < nrows - 1; r++)
                grid[nrows-1][c] ^= grid[r][c];
        grid[nrows-1][ncols-1] = 1'($urandom_range(0, 1));
        case (kind)
            FRAME_ONE_FLIP:
            begin
                r = $urandom_range(0, nrows - 1);
                c = $urandom_range(0, ncols - 1);
                grid[r][c] = ~grid[r][c];
            end
            FRAME_FEW_FLIPS:
            begin
                flips = $urandom_range(2, 4);
                repeat (flips)
                begin
                    r = $urandom_range(0, nrows - 1);
                    c = $urandom_range(0, ncols - 1);
                    grid[r][c] = ~grid[r][c];
                end
            end
            FRAME_NOISE:
                for (r = 0; r < nrows; r++)
                    grid[r] = $urandom;
            FRAME_ALL_PARITY_BAD:
            begin
                for (r = 0; r < nrows - 1; r++)
                    grid[r][ncols-1] = ~grid[r][ncols-1];
                for (c = 0; c < ncols - 1; c++)
                    grid[nrows-1][c] = ~grid[nrows-1][c];
            end
            default: ;
        endcase
        k = 0;
        for (r = 0; r < nrows; r++)
            for (c = 0; c < ncols; c++)
            begin
                if (k == split_at)
                begin
                    drain();
                    poke_spare_reg();
                end
                push_bit(grid[r][c], 1'b0, REP_CLEAN);
                k++;
            end
    endtask

    function automatic frame_kind_t pick_kind();
        int w;
        w = $urandom_range(0, 99);
        if (w < 20)
            return FRAME_CLEAN;
        if (w < 65)
            return FRAME_ONE_FLIP;
        if (w < 85)
            return FRAME_FEW_FLIPS;
        return FRAME_NOISE;
    endfunction

    initial
    begin : report_sink
        frame_report_t got;
        frame_report_t want;
        int            stall;
        rep_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                rep_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                rep_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rep_ch.ready <= 1'b1;
            do @(posedge clk); while (rep_ch.valid !== 1'b1);
            got = {rep_ch.bad_row_count, rep_ch.bad_col_count, rep_ch.single_error,
                   rep_ch.error_row, rep_ch.error_col, rep_ch.received_bit,
                   rep_ch.corrected_bit};
            if (pending_reports.size() == 0)
            begin
                if (mismatch_count < MAX_SHOWN)
                    $display("%0t: report with no frame pending: %p", $realtime, got);
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < MAX_SHOWN)
                    begin
                        $display("%0t: report mismatch", $realtime);
                        $display("  expected rows=%0d cols=%0d single=%0d at=(%0d,%0d) rx=%0d fix=%0d",
                                 want.bad_rows, want.bad_cols, want.single, want.err_row,
                                 want.err_col, want.rx, want.fix);
                        $display("  actual   rows=%0d cols=%0d single=%0d at=(%0d,%0d) rx=%0d fix=%0d",
                                 got.bad_rows, got.bad_cols, got.single, got.err_row,
                                 got.err_col, got.rx, got.fix);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int          i;
        int          phase;
        int          r_raw;
        int          c_raw;
        int          nrows;
        int          ncols;
        int          n_frames;
        int          f;
        int          split;
        int          tail;
        frame_kind_t kind;
        bits_ch.valid  <= 1'b0;
        bits_ch.rx_bit <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_FRAME_ROWS;
        cfg_data       <= '0;
        rows_cfg = DIM_RESET;
        cols_cfg = DIM_RESET;
        clear_frame();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dimensions below range act as 2x2
        set_frame(DIM_W'(0), DIM_W'(1));
        for (i = 0; i < DIRECTED_LEN; i++)
            push_bit(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].rep);
        drain();

        phase = 0;
        while (bits_sent < DIRECTED_LEN + RANDOM_BITS)
        begin
            case (phase)
                0:
                begin
                    r_raw = 63;
                    c_raw = 2;
                end
                1:
                begin
                    r_raw = 2;
                    c_raw = 33;
                end
                2:
                begin
                    r_raw = int'(DIM_RESET);
                    c_raw = int'(DIM_RESET);
                end
                3:
                begin
                    r_raw = 2;
                    c_raw = 2;
                end
                default:
                begin
                    r_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                        : $urandom_range(2, 7);
                    c_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                        : $urandom_range(2, 7);
                end
            endcase
            set_frame(DIM_W'(r_raw), DIM_W'(c_raw));
            nrows = dim_of(DIM_W'(r_raw));
            ncols = dim_of(DIM_W'(c_raw));
            idle_on = (phase % 5 != 2) && (phase != 3);
            if (phase == 3)
                hold_off_cycles = LONG_HOLD;
            if (phase < 2)
                n_frames = 2;
            else if (phase == 3)
                n_frames = 12;
            else if (nrows * ncols > 64)
                n_frames = 1;
            else
                n_frames = $urandom_range(1, 5);
            for (f = 0; f < n_frames; f++)
            begin
                kind  = (phase < 2 && f == 0) ? FRAME_ALL_PARITY_BAD : pick_kind();
                split = (phase % 3 == 1 && f == 0) ? $urandom_range(1, nrows * ncols - 1) : -1;
                send_frame(nrows, ncols, kind, split);
            end
            // leave a partial frame for the next restart to discard
            if ($urandom_range(0, 2) == 0)
            begin
                tail = $urandom_range(1, nrows * ncols - 1);
                repeat (tail) push_bit(1'($urandom_range(0, 1)), 1'b0, REP_CLEAN);
            end
            drain();
            phase++;
        end

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
